// ----- src/sem_pkg.sv -----
// Shared types and constants of the RGB Sobel edge magnitude block.
package sem_pkg;

	// Default frame limits; the top level turns these into parameters.
	localparam int DEF_MAX_WIDTH  = 1024;
	localparam int DEF_MAX_HEIGHT = 1024;

	localparam int CFG_DIM_W = 11;
	localparam int CFG_IDX_W = 1;
	localparam int CH_W      = 8;
	localparam int PIX_W     = 3 * CH_W;
	localparam int GRAD_W    = 11;
	localparam int SUM_W     = 21;
	localparam int ROOT_W    = 8;

	localparam int MID_DEPTH = 4;
	localparam int OUT_DEPTH = 2;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_IMAGE_WIDTH  = 1'b0,
		REG_IMAGE_HEIGHT = 1'b1
	} cfg_reg_t;

	// One column of the neighborhood plus what the front decided about it.
	typedef struct packed {
		logic [PIX_W-1:0] up;
		logic [PIX_W-1:0] mid;
		logic [PIX_W-1:0] pix;
		logic             res;
		logic             frame_end;
		logic             row_top;
		logic             row_bot;
		logic             col_left;
		logic             col_right;
	} column_t;

	typedef struct packed {
		logic [CH_W-1:0] red;
		logic [CH_W-1:0] green;
		logic [CH_W-1:0] blue;
		logic            frame_end;
	} result_t;

endpackage

// ----- src/sem_fifo.sv -----
// Small first-in first-out queue built from registers.
module sem_fifo #(
	parameter int DEPTH = 4,
	parameter int WIDTH = 8
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       push,
	input  logic [WIDTH-1:0]           din,
	input  logic                       pop,
	output logic [WIDTH-1:0]           dout,
	output logic                       empty,
	output logic                       full,
	output logic [$clog2(DEPTH+1)-1:0] count
);

	localparam int PW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PW-1:0]    wr_ptr_q;
	logic [PW-1:0]    rd_ptr_q;
	logic [CW-1:0]    count_q;
	logic             do_push;
	logic             do_pop;

	assign do_push = push && (count_q != CW'(DEPTH));
	assign do_pop  = pop && (count_q != '0);
	assign empty   = (count_q == '0);
	assign full    = (count_q == CW'(DEPTH));
	assign count   = count_q;
	assign dout    = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
			end
			count_q <= count_q + CW'(do_push) - CW'(do_pop);
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= din;
		end
	end

endmodule

// ----- src/sem_front.sv -----
// Front end: raster counters, classification of each request and the line store.
module sem_front #(
	parameter int MAX_WIDTH  = sem_pkg::DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = sem_pkg::DEF_MAX_HEIGHT
) (
	input  logic                                     clk,
	input  logic                                     arst_n,
	input  logic                                     restart,
	input  logic [$clog2(MAX_WIDTH+1)-1:0]           img_width,
	input  logic [$clog2(MAX_HEIGHT+1)-1:0]          img_height,
	input  logic                                     push,
	output logic                                     full,
	input  logic [sem_pkg::CH_W-1:0]                 in_red,
	input  logic [sem_pkg::CH_W-1:0]                 in_green,
	input  logic [sem_pkg::CH_W-1:0]                 in_blue,
	input  logic                                     pad,
	input  logic [$clog2(sem_pkg::MID_DEPTH+1)-1:0]  mid_count,
	output logic                                     col_push,
	output sem_pkg::column_t                         col
);

	localparam int AW   = $clog2(MAX_WIDTH);
	localparam int WW   = $clog2(MAX_WIDTH + 1);
	localparam int RW   = $clog2(MAX_HEIGHT + 2);
	localparam int CNTW = $clog2(sem_pkg::MID_DEPTH + 1);
	localparam int FW   = CNTW + 1;
	localparam int PW   = sem_pkg::PIX_W;

	logic [AW-1:0] col_q;
	logic [RW-1:0] row_q;
	logic [WW-1:0] drain_q;

	logic          accept;
	logic [FW-1:0] level;
	logic          in_frame;
	logic          first_case;
	logic          wrap_case;
	logic          fend;
	logic [RW-1:0] h_ext;
	logic [RW-1:0] ro;
	logic [AW-1:0] co;
	logic [WW-1:0] ci_inc;
	logic [PW-1:0] pix;

	logic              valid_s1;
	logic [AW-1:0]     addr_s1;
	logic [PW-1:0]     pix_s1;
	logic [5:0]        flags_s1;
	logic [2*PW-1:0]   rd_s1;
	logic              fwd_s1;
	logic [2*PW-1:0]   fwd_data_s1;
	logic [2*PW-1:0]   eff;
	logic [2*PW-1:0]   line_mem [MAX_WIDTH];

	assign level  = FW'(mid_count) + FW'(valid_s1);
	assign full   = (level >= FW'(sem_pkg::MID_DEPTH));
	assign accept = push && !full;

	always_comb begin
		h_ext      = RW'(img_height);
		in_frame   = (row_q < h_ext);
		pix        = (in_frame && !pad) ? {in_blue, in_green, in_red} : '0;
		first_case = (col_q != '0) && (row_q != '0);
		wrap_case  = (col_q == '0) && (row_q >= RW'(2));
		ro         = first_case ? row_q - RW'(1) : row_q - RW'(2);
		co         = first_case ? col_q - AW'(1) : AW'(img_width - WW'(1));
		fend       = !in_frame && (drain_q >= img_width);
		ci_inc     = WW'(col_q) + WW'(1);
	end

	// The store keeps the two rows above: upper half is two rows up.
	assign eff = fwd_s1 ? fwd_data_s1 : rd_s1;

	always_ff @(posedge clk) begin
		if (accept) begin
			rd_s1 <= line_mem[col_q];
		end
		if (valid_s1) begin
			line_mem[addr_s1] <= {eff[PW-1:0], pix_s1};
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			addr_s1     <= col_q;
			pix_s1      <= pix;
			// A one-pixel row reads the entry that is being written right now.
			fwd_s1      <= valid_s1 && (addr_s1 == col_q);
			fwd_data_s1 <= {eff[PW-1:0], pix_s1};
			flags_s1[5] <= (first_case || wrap_case) && (ro < h_ext);
			flags_s1[4] <= fend && (ro == h_ext - RW'(1))
				&& (WW'(co) == img_width - WW'(1));
			flags_s1[3] <= (ro != '0);
			flags_s1[2] <= (ro + RW'(1) < h_ext);
			flags_s1[1] <= (co != '0);
			flags_s1[0] <= (WW'(co) + WW'(1) < img_width);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			col_q    <= '0;
			row_q    <= '0;
			drain_q  <= '0;
		end else begin
			valid_s1 <= accept;
			if (restart || (accept && fend)) begin
				col_q   <= '0;
				row_q   <= '0;
				drain_q <= '0;
			end else if (accept) begin
				if (!in_frame) begin
					drain_q <= drain_q + WW'(1);
				end
				if (ci_inc >= img_width) begin
					col_q <= '0;
					row_q <= row_q + RW'(1);
				end else begin
					col_q <= AW'(ci_inc);
				end
			end
		end
	end

	assign col_push      = valid_s1;
	assign col.up        = eff[2*PW-1:PW];
	assign col.mid       = eff[PW-1:0];
	assign col.pix       = pix_s1;
	assign col.res       = flags_s1[5];
	assign col.frame_end = flags_s1[4];
	assign col.row_top   = flags_s1[3];
	assign col.row_bot   = flags_s1[2];
	assign col.col_left  = flags_s1[1];
	assign col.col_right = flags_s1[0];

endmodule

// ----- src/sem_back.sv -----
// Back end: 3x3 window, Sobel gradients, squared sum and a pipelined integer root.
module sem_back (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              col_empty,
	output logic              col_pop,
	input  sem_pkg::column_t  col,
	input  logic              res_full,
	output logic              res_push,
	output sem_pkg::result_t  res
);

	localparam int CH_W   = sem_pkg::CH_W;
	localparam int PW     = sem_pkg::PIX_W;
	localparam int GW     = sem_pkg::GRAD_W;
	localparam int SW     = sem_pkg::SUM_W;
	localparam int RTW    = sem_pkg::ROOT_W;

	logic [PW-1:0] win_q [3][3];

	logic       valid_s1;
	logic       fe_s1;
	logic [3:0] mask_s1;

	logic                 valid_s2;
	logic                 fe_s2;
	logic signed [GW-1:0] gx_s2 [3];
	logic signed [GW-1:0] gy_s2 [3];

	logic           rt_valid_sk [RTW+1];
	logic           rt_fe_sk    [RTW+1];
	logic [SW-1:0]  rt_sum_sk   [RTW+1][3];
	logic [RTW-1:0] rt_root_sk  [RTW+1][3];

	logic                   adv;
	logic signed [GW-1:0]   m [3][3];
	logic [2:0]             row_ok;
	logic [2:0]             col_ok;
	logic signed [GW-1:0]   gx [3];
	logic signed [GW-1:0]   gy [3];
	logic signed [2*GW-1:0] sq_x [3];
	logic signed [2*GW-1:0] sq_y [3];
	logic [SW-1:0]          sums [3];
	logic [RTW-1:0]         cand [RTW][3];
	logic [2*RTW-1:0]       prod [RTW][3];
	logic [RTW-1:0]         nxt  [RTW][3];

	assign adv      = !(rt_valid_sk[RTW] && res_full);
	assign col_pop  = adv && !col_empty;
	assign res_push = rt_valid_sk[RTW] && !res_full;

	always_comb begin
		row_ok = {mask_s1[2], 1'b1, mask_s1[3]};
		col_ok = {mask_s1[0], 1'b1, mask_s1[1]};
		for (int ch = 0; ch < 3; ch++) begin
			for (int r = 0; r < 3; r++) begin
				for (int c = 0; c < 3; c++) begin
					m[r][c] = (row_ok[r] && col_ok[c])
						? GW'(win_q[r][c][ch*CH_W +: CH_W]) : '0;
				end
			end
			gx[ch] = m[0][2] - m[0][0] + ((m[1][2] - m[1][0]) <<< 1) + m[2][2] - m[2][0];
			gy[ch] = m[2][0] - m[0][0] + ((m[2][1] - m[0][1]) <<< 1) + m[2][2] - m[0][2];
			sq_x[ch] = gx_s2[ch] * gx_s2[ch];
			sq_y[ch] = gy_s2[ch] * gy_s2[ch];
			sums[ch] = SW'(sq_x[ch] + sq_y[ch]);
		end
	end

	// Each root stage settles one bit: keep it while cand*(cand-1) < sum.
	always_comb begin
		for (int k = 0; k < RTW; k++) begin
			for (int ch = 0; ch < 3; ch++) begin
				cand[k][ch] = rt_root_sk[k][ch] | (RTW'(1) << (RTW - 1 - k));
				prod[k][ch] = (2*RTW)'(cand[k][ch]) * (2*RTW)'(cand[k][ch] - RTW'(1));
				nxt[k][ch]  = (SW'(prod[k][ch]) < rt_sum_sk[k][ch])
					? cand[k][ch] : rt_root_sk[k][ch];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			for (int k = 0; k <= RTW; k++) begin
				rt_valid_sk[k] <= 1'b0;
			end
		end else if (adv) begin
			valid_s1       <= col_pop && col.res;
			valid_s2       <= valid_s1;
			rt_valid_sk[0] <= valid_s2;
			for (int k = 0; k < RTW; k++) begin
				rt_valid_sk[k+1] <= rt_valid_sk[k];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (col_pop) begin
			for (int r = 0; r < 3; r++) begin
				win_q[r][0] <= win_q[r][1];
				win_q[r][1] <= win_q[r][2];
			end
			win_q[0][2] <= col.up;
			win_q[1][2] <= col.mid;
			win_q[2][2] <= col.pix;
			fe_s1       <= col.frame_end;
			mask_s1     <= {col.row_top, col.row_bot, col.col_left, col.col_right};
		end
		if (adv) begin
			fe_s2       <= fe_s1;
			rt_fe_sk[0] <= fe_s2;
			for (int ch = 0; ch < 3; ch++) begin
				gx_s2[ch]         <= gx[ch];
				gy_s2[ch]         <= gy[ch];
				rt_sum_sk[0][ch]  <= sums[ch];
				rt_root_sk[0][ch] <= '0;
			end
			for (int k = 0; k < RTW; k++) begin
				rt_fe_sk[k+1] <= rt_fe_sk[k];
				for (int ch = 0; ch < 3; ch++) begin
					rt_sum_sk[k+1][ch]  <= rt_sum_sk[k][ch];
					rt_root_sk[k+1][ch] <= nxt[k][ch];
				end
			end
		end
	end

	assign res.red       = rt_root_sk[RTW][0];
	assign res.green     = rt_root_sk[RTW][1];
	assign res.blue      = rt_root_sk[RTW][2];
	assign res.frame_end = rt_fe_sk[RTW];

endmodule

// ----- src/sobel_edge_magnitude_rgb_top.sv -----
// Top level of the RGB Sobel edge magnitude block.
// Pixels enter in raster order, one request per clock, and while neither queue fills the
// block sustains one pixel per clock on both sides; the line store, a single memory that
// is read and then rewritten at the same column, takes one read and one write per pixel on
// separate ports and sets that figure. Each channel gets a 3x3 Sobel operator with zeros
// outside the frame, and the result is the rounded gradient magnitude clamped to 255. The
// result of a pixel appears only after width+1 further requests, so after the last pixel of
// a frame the host sends width+1 requests with pad set; frame_end marks the result of the
// frame's last pixel. A request passes the front-end register stage, which keeps the
// counters and the line store, then the queue behind it and then the back end, which holds
// the window, the gradients and an eight-stage root pipeline. A short queue between the two
// and another one at the results let either side stall on its own. Writing image_width or
// image_height restarts the frame; write them only while the block is idle. There is no
// clearing pass.
module sobel_edge_magnitude_rgb_top #(
	parameter int MAX_WIDTH  = sem_pkg::DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = sem_pkg::DEF_MAX_HEIGHT
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          push,
	output logic                          full,
	input  logic [sem_pkg::CH_W-1:0]      in_red,
	input  logic [sem_pkg::CH_W-1:0]      in_green,
	input  logic [sem_pkg::CH_W-1:0]      in_blue,
	input  logic                          pad,
	output logic                          empty,
	input  logic                          pop,
	output logic [sem_pkg::CH_W-1:0]      edge_red,
	output logic [sem_pkg::CH_W-1:0]      edge_green,
	output logic [sem_pkg::CH_W-1:0]      edge_blue,
	output logic                          frame_end,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [sem_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [sem_pkg::CFG_DIM_W-1:0] cfg_data
);

	localparam int WW   = $clog2(MAX_WIDTH + 1);
	localparam int HW   = $clog2(MAX_HEIGHT + 1);
	localparam int CNTW = $clog2(sem_pkg::MID_DEPTH + 1);
	localparam int OCW  = $clog2(sem_pkg::OUT_DEPTH + 1);
	localparam int CLW  = $bits(sem_pkg::column_t);
	localparam int RSW  = $bits(sem_pkg::result_t);
	localparam int RST_W = (sem_pkg::DEF_MAX_WIDTH > MAX_WIDTH) ? MAX_WIDTH
		: sem_pkg::DEF_MAX_WIDTH;
	localparam int RST_H = (sem_pkg::DEF_MAX_HEIGHT > MAX_HEIGHT) ? MAX_HEIGHT
		: sem_pkg::DEF_MAX_HEIGHT;

	logic [WW-1:0] width_q;
	logic [HW-1:0] height_q;
	logic          cfg_write;

	logic              col_push;
	logic              col_pop;
	logic              col_empty;
	logic [CNTW-1:0]   mid_count;
	sem_pkg::column_t  col_in;
	sem_pkg::column_t  col_out;
	logic [CLW-1:0]    col_vec;

	logic              res_push;
	logic              res_full;
	sem_pkg::result_t  res_in;
	logic [RSW-1:0]    res_vec;
	logic [OCW-1:0]    res_count;
	sem_pkg::result_t  res_out;

	// Configuration is always taken at once; a write also restarts the frame.
	assign cfg_ready = 1'b1;
	assign cfg_write = cfg_valid && cfg_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= WW'(RST_W);
			height_q <= HW'(RST_H);
		end else if (cfg_write) begin
			unique case (sem_pkg::cfg_reg_t'(cfg_index))
				sem_pkg::REG_IMAGE_WIDTH: begin
					// Zero means one pixel; anything above the maximum saturates.
					if (cfg_data == '0) begin
						width_q <= WW'(1);
					end else if (32'(cfg_data) > 32'(MAX_WIDTH)) begin
						width_q <= WW'(MAX_WIDTH);
					end else begin
						width_q <= WW'(cfg_data);
					end
				end
				sem_pkg::REG_IMAGE_HEIGHT: begin
					if (cfg_data == '0) begin
						height_q <= HW'(1);
					end else if (32'(cfg_data) > 32'(MAX_HEIGHT)) begin
						height_q <= HW'(MAX_HEIGHT);
					end else begin
						height_q <= HW'(cfg_data);
					end
				end
			endcase
		end
	end

	sem_front #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.restart    (cfg_write),
		.img_width  (width_q),
		.img_height (height_q),
		.push       (push),
		.full       (full),
		.in_red     (in_red),
		.in_green   (in_green),
		.in_blue    (in_blue),
		.pad        (pad),
		.mid_count  (mid_count),
		.col_push   (col_push),
		.col        (col_in)
	);

	// The front end never overruns this queue: it counts its own staged request.
	sem_fifo #(
		.DEPTH (sem_pkg::MID_DEPTH),
		.WIDTH (CLW)
	) u_mid_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (col_push),
		.din    (col_in),
		.pop    (col_pop),
		.dout   (col_vec),
		.empty  (col_empty),
		.full   (),
		.count  (mid_count)
	);

	assign col_out = sem_pkg::column_t'(col_vec);

	sem_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.col_empty (col_empty),
		.col_pop   (col_pop),
		.col       (col_out),
		.res_full  (res_full),
		.res_push  (res_push),
		.res       (res_in)
	);

	// Result queue: a finished result waits here while new pixels keep flowing.
	sem_fifo #(
		.DEPTH (sem_pkg::OUT_DEPTH),
		.WIDTH (RSW)
	) u_out_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (res_push),
		.din    (res_in),
		.pop    (pop),
		.dout   (res_vec),
		.empty  (empty),
		.full   (res_full),
		.count  (res_count)
	);

	assign res_out    = sem_pkg::result_t'(res_vec);
	assign edge_red   = res_out.red;
	assign edge_green = res_out.green;
	assign edge_blue  = res_out.blue;
	// The count gates frame_end so that it stays low while the result queue is empty.
	assign frame_end  = res_out.frame_end && (res_count != '0);

endmodule

// ----- src/sem_checker.sv -----
// Port-level checker for the RGB Sobel edge magnitude block, bound to the top level.
module sem_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          push,
	input logic                          full,
	input logic [sem_pkg::CH_W-1:0]      in_red,
	input logic [sem_pkg::CH_W-1:0]      in_green,
	input logic [sem_pkg::CH_W-1:0]      in_blue,
	input logic                          pad,
	input logic                          empty,
	input logic                          pop,
	input logic [sem_pkg::CH_W-1:0]      edge_red,
	input logic [sem_pkg::CH_W-1:0]      edge_green,
	input logic [sem_pkg::CH_W-1:0]      edge_blue,
	input logic                          frame_end,
	input logic                          cfg_valid,
	input logic                          cfg_ready,
	input logic [sem_pkg::CFG_IDX_W-1:0] cfg_index,
	input logic [sem_pkg::CFG_DIM_W-1:0] cfg_data
);

	// Configuration writes are never held off.
	a_cfg_ready: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid |-> cfg_ready)
		else $error("configuration write was stalled");

	// The front end can only fill up after it took a request.
	a_full_rise: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(full) |-> $past(push && !full))
		else $error("full rose without an accepted request");

	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> !empty)
		else $error("waiting result vanished");

	a_res_stable: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> ($stable(edge_red) && $stable(edge_green)
			&& $stable(edge_blue) && $stable(frame_end)))
		else $error("waiting result changed");

endmodule

bind sobel_edge_magnitude_rgb_top sem_checker u_sem_checker (.*);
